/* rtl/core/efla_pkg.sv */
// shared types and constants for the embedded free-list allocator
// used by efla_ctrl, efla_dp and the top level; no dependencies
package efla_pkg;

  localparam int unsigned IdxW     = 8;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned OffW     = 24;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned Depth    = 256;
  localparam logic [IdxW-1:0] MaxBlocks = 8'd255;

  // register indexes of the config port
  localparam logic CfgBlockCount = 1'b0;
  localparam logic CfgBlockSize  = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_REINIT  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FIN_NONE   = 2'd0,
    FIN_DIRECT = 2'd1,
    FIN_ALLOC  = 2'd2,
    FIN_REINIT = 2'd3
  } fin_e;

  typedef struct packed {
    logic capture;
    logic link_rd;
    logic walk_clr;
    logic walk_wr;
    fin_e fin;
  } efla_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic pool_empty;
    logic pool_none;
    logic walk_last;
    logic out_free;
  } efla_stat_t;

endpackage

/* rtl/core/efla_ctrl.sv */
// controller state machine of the free-list allocator
// depends on efla_pkg; drives efla_dp through efla_cmd_t
module efla_ctrl import efla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  efla_stat_t stat_i,
  output efla_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_LINK = 5'b00100,
    S_WALK = 5'b01000,
    S_FINR = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '{capture: 1'b0, link_rd: 1'b0, walk_clr: 1'b0, walk_wr: 1'b0, fin: FIN_NONE};
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat_i.cmd)
          CMD_ALLOC: begin
            if (!stat_i.pool_empty) begin
              cmd_o.link_rd = 1'b1;
              state_d       = S_LINK;
            end else if (stat_i.out_free) begin
              cmd_o.fin = FIN_DIRECT;
              state_d   = S_IDLE;
            end
          end
          CMD_REINIT: begin
            if (!stat_i.pool_none) begin
              cmd_o.walk_clr = 1'b1;
              state_d        = S_WALK;
            end else if (stat_i.out_free) begin
              cmd_o.fin = FIN_REINIT;
              state_d   = S_IDLE;
            end
          end
          default: begin
            if (stat_i.out_free) begin
              cmd_o.fin = FIN_DIRECT;
              state_d   = S_IDLE;
            end
          end
        endcase
      end
      S_LINK: begin
        if (stat_i.out_free) begin
          cmd_o.fin = FIN_ALLOC;
          state_d   = S_IDLE;
        end
      end
      S_WALK: begin
        cmd_o.walk_wr = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_FINR;
        end
      end
      S_FINR: begin
        if (stat_i.out_free) begin
          cmd_o.fin = FIN_REINIT;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_link_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.link_rd |=> state_q == S_LINK)
    else $error("link read not followed by link state");

  a_walk_ends_in_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && stat_i.walk_last) |=> state_q == S_FINR)
    else $error("walk did not finish");

  a_idle_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin != FIN_NONE |=> state_q == S_IDLE)
    else $error("state left busy after result");

endmodule

/* rtl/core/efla_dp.sv */
// datapath of the free-list allocator: link memory, head, free count,
// config registers, offset multiplier and result register; uses efla_pkg
module efla_dp import efla_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  efla_cmd_t           cmd_i,
  output efla_stat_t          stat_o,
  input  logic [1:0]          command_i,
  input  logic [IdxW-1:0]     release_index_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [IdxW-1:0]     block_index_o,
  output logic [OffW-1:0]     byte_offset_o,
  output logic [IdxW-1:0]     free_count_o
);

  logic [IdxW-1:0]  block_count_q;
  logic [SizeW-1:0] block_size_q;
  cmd_e             cmd_q;
  logic [IdxW-1:0]  rel_q;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  free_q, free_d;
  logic [IdxW-1:0]  cnt_q;
  logic [IdxW-1:0]  link_q;
  logic [IdxW-1:0]  pool_n;
  logic             rel_ok;

  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [IdxW-1:0]  fcnt_q;
  logic             out_load;

  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [IdxW-1:0]  mem_wdata;
  logic [IdxW-1:0]  mem [Depth];

  assign pool_n   = (block_count_q > MaxBlocks) ? MaxBlocks : block_count_q;
  assign rel_ok   = rel_q < pool_n;
  assign out_load = cmd_i.fin != FIN_NONE;

  assign stat_o.cmd        = cmd_q;
  assign stat_o.pool_empty = free_q == '0;
  assign stat_o.pool_none  = pool_n == '0;
  assign stat_o.walk_last  = cnt_q == (pool_n - 8'd1);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  // list update and result fields
  always_comb begin
    head_d   = head_q;
    free_d   = free_q;
    status_d = ST_OK;
    idx_d    = '0;
    off_d    = '0;
    unique case (cmd_i.fin)
      FIN_ALLOC: begin
        head_d = link_q;
        free_d = free_q - 8'd1;
        idx_d  = head_q;
        off_d  = OffW'(head_q) * OffW'(block_size_q);
      end
      FIN_REINIT: begin
        head_d = '0;
        free_d = pool_n;
      end
      FIN_DIRECT: begin
        if (cmd_q == CMD_ALLOC) begin
          status_d = ST_EMPTY;
        end else if (cmd_q == CMD_RELEASE) begin
          if (!rel_ok) begin
            status_d = ST_RANGE;
          end else begin
            head_d = rel_q;
            free_d = (free_q != 8'hFF) ? free_q + 8'd1 : free_q;
          end
        end
      end
      default: begin
        head_d = head_q;
      end
    endcase
  end

  assign mem_we    = cmd_i.walk_wr ||
                     (cmd_i.fin == FIN_DIRECT && cmd_q == CMD_RELEASE && rel_ok);
  assign mem_waddr = cmd_i.walk_wr ? cnt_q : rel_q;
  assign mem_wdata = cmd_i.walk_wr ? cnt_q + 8'd1 : head_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.link_rd) begin
      link_q <= mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= 8'd255;
      block_size_q  <= 16'd16;
      cmd_q         <= CMD_ALLOC;
      rel_q         <= '0;
      head_q        <= '0;
      free_q        <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgBlockCount: block_count_q <= cfg_data_i[IdxW-1:0];
          CfgBlockSize:  block_size_q  <= cfg_data_i[SizeW-1:0];
          default:       block_size_q  <= block_size_q;
        endcase
      end
      if (cmd_i.capture) begin
        cmd_q <= cmd_e'(command_i);
        rel_q <= release_index_i;
      end
      if (cmd_i.walk_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.walk_wr) begin
        cnt_q <= cnt_q + 8'd1;
      end
      head_q <= head_d;
      free_q <= free_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      idx_q    <= idx_d;
      off_q    <= off_d;
      fcnt_q   <= free_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign block_index_o = idx_q;
  assign byte_offset_o = off_q;
  assign free_count_o  = fcnt_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("result overwritten while stalled");

  a_alloc_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin == FIN_ALLOC |-> free_q != '0)
    else $error("allocate from empty pool");

  a_walk_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_wr |-> cnt_q < pool_n)
    else $error("walk beyond pool");

  a_reinit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin == FIN_REINIT |=> free_q == $past(pool_n) && head_q == '0)
    else $error("reinitialise left wrong list state");

endmodule

/* rtl/core/embedded_free_list_allocator.sv */
// top level of the embedded free-list allocator
// instantiates efla_ctrl and efla_dp; uses efla_pkg
//
// Usage: one command beat enters on in_valid_i/in_stall_o (command_i,
// release_index_i) and exactly one result beat leaves on
// out_valid_o/out_stall_i (status_o, block_index_o, byte_offset_o,
// free_count_o). One command is in flight at a time.
// Release, empty allocate and the unused command finish straight from
// the execute state; allocate adds the registered read of the link
// memory at the head; reinitialise walks the pool, writing one link
// entry per cycle, then finishes, or finishes straight from the execute
// state with an empty pool.
// The next command beat is taken in the cycle after the result is loaded,
// even while that result is still held by a stalling receiver; a command
// then waits for the result register before finishing.
// Reset clears the free count and head, so the pool is empty until a
// reinitialise or a release; block_count resets to 255 and block_size to 16.
// Config writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at once
// and must be made while no command is in flight.
module embedded_free_list_allocator import efla_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [IdxW-1:0]     release_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [IdxW-1:0]     block_index_o,
  output logic [OffW-1:0]     byte_offset_o,
  output logic [IdxW-1:0]     free_count_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  efla_cmd_t  ctl_cmd;
  efla_stat_t dp_stat;

  efla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  efla_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctl_cmd),
    .stat_o          (dp_stat),
    .command_i       (command_i),
    .release_index_i (release_index_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .block_index_o   (block_index_o),
    .byte_offset_o   (byte_offset_o),
    .free_count_o    (free_count_o)
  );

endmodule
